### rtl/b64bd_pkg.sv
// ----------------------------------------------------------------------------
// b64bd_pkg
// Types, constants and character class tables for the base64 block decoder.
// ----------------------------------------------------------------------------
package b64bd_pkg;

    localparam int unsigned LANES       = 16;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned SEXTET_W    = 6;
    localparam int unsigned BLOCK_BYTES = 12;
    localparam int unsigned DATA_W      = BLOCK_BYTES * 8;
    localparam int unsigned COUNT_W     = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_STEP = COUNT_W'(BLOCK_BYTES);
    localparam logic [CHAR_W-1:0]  CHAR_SLASH = 8'h2F;

    typedef struct packed {
        logic [SEXTET_W-1:0] value;
        logic                ok;
    } lane_res_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              ok;
    } merge_res_t;

    // class bits on the low nibble
    function automatic logic [7:0] lo_class(input logic [3:0] ln);
        logic [7:0] r;
        unique case (ln) inside
            4'h0:           r = 8'h15;
            [4'h1:4'h9]:    r = 8'h11;
            4'hA:           r = 8'h13;
            4'hB, 4'hF:     r = 8'h1A;
            [4'hC:4'hE]:    r = 8'h1B;
            default:        r = 8'h1B;
        endcase
        return r;
    endfunction

    // class bits on the high nibble
    function automatic logic [7:0] hi_class(input logic [3:0] hn);
        logic [7:0] r;
        unique case (hn) inside
            4'h2:           r = 8'h01;
            4'h3:           r = 8'h02;
            4'h4, 4'h6:     r = 8'h04;
            4'h5, 4'h7:     r = 8'h08;
            default:        r = 8'h10;
        endcase
        return r;
    endfunction

    // offset added to the character, mod 256
    function automatic logic [7:0] char_offset(input logic [3:0] idx);
        logic [7:0] r;
        unique case (idx) inside
            4'h1:           r = 8'd16;
            4'h2:           r = 8'd19;
            4'h3:           r = 8'd4;
            4'h4, 4'h5:     r = 8'd191;
            4'h6, 4'h7:     r = 8'd185;
            default:        r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/b64bd_lane.sv
// ----------------------------------------------------------------------------
// b64bd_lane
// Classifies one character and maps it to its 6-bit value.
// ----------------------------------------------------------------------------
module b64bd_lane (
    input  logic [7:0]           ch,
    output b64bd_pkg::lane_res_t res
);
    import b64bd_pkg::*;

    logic [3:0] hn;
    logic [3:0] ln;
    logic [3:0] idx;
    logic [7:0] sum;

    assign hn  = ch[7:4];
    assign ln  = ch[3:0];
    // '/' borrows the offset of the nibble row below it
    assign idx = (ch == CHAR_SLASH) ? (hn - 4'd1) : hn;
    assign sum = ch + char_offset(idx);

    assign res.value = sum[SEXTET_W-1:0];
    assign res.ok    = ((lo_class(ln) & hi_class(hn)) == 8'h00);

endmodule

### rtl/b64bd_merge.sv
// ----------------------------------------------------------------------------
// b64bd_merge
// Combines the lane results: block validity and the 12-byte big-endian pack.
// ----------------------------------------------------------------------------
module b64bd_merge (
    input  b64bd_pkg::lane_res_t lanes [b64bd_pkg::LANES],
    output b64bd_pkg::merge_res_t res
);
    import b64bd_pkg::*;

    localparam int unsigned GROUPS = LANES / 4;

    logic [LANES-1:0] ok_vec;
    logic [23:0]      grp [GROUPS];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            ok_vec[i] = lanes[i].ok;
        end
    end

    always_comb
    begin
        res.data = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            grp[g] = {lanes[4*g].value, lanes[4*g+1].value,
                      lanes[4*g+2].value, lanes[4*g+3].value};
            // first byte of each triple is the top of the 24-bit word
            res.data[(3*g)*8   +: 8] = grp[g][23:16];
            res.data[(3*g+1)*8 +: 8] = grp[g][15:8];
            res.data[(3*g+2)*8 +: 8] = grp[g][7:0];
        end
        res.ok = &ok_vec;
    end

endmodule

### rtl/base64_block_decoder_core.sv
// ----------------------------------------------------------------------------
// base64_block_decoder_core
// Decodes 16 base64 characters per word into 12 bytes, with buffer state.
// ----------------------------------------------------------------------------
// Takes words of 16 characters and returns one result word per accepted word:
// sixteen lanes classify the characters in parallel into a register stage, then
// the merged block is checked against the buffer state (stop flag, saturating
// byte count) on its way into the output register. Throughput is one word per
// cycle while out_stall is low; the per-buffer state update in the second stage
// is the only serial dependency.
// ----------------------------------------------------------------------------
module base64_block_decoder_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [63:0]                   chars_low,
    input  logic [63:0]                   chars_high,
    input  logic                          last_block,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [63:0]                   bytes_low,
    output logic [31:0]                   bytes_high,
    output logic                          accepted,
    output logic [b64bd_pkg::COUNT_W-1:0] written_count
);
    import b64bd_pkg::*;

    logic [LANES*CHAR_W-1:0] block;
    lane_res_t               lane_res [LANES];
    merge_res_t              merged;

    // stage 1: lane results
    logic       s1_valid_reg;
    logic       s1_valid_next;
    lane_res_t  s1_lane_reg [LANES];
    logic       s1_last_reg;

    // stage 2: output register and buffer state
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DATA_W-1:0]  out_data_reg;
    logic               accepted_reg;
    logic [COUNT_W-1:0] written_reg;
    logic               stopped_reg;
    logic               stopped_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic               s2_load;
    logic               s1_load;
    logic               acc;
    logic [COUNT_W-1:0] count_inc;

    assign block = {chars_high, chars_low};

    genvar gi;
    generate
        for (gi = 0; gi < LANES; gi++)
        begin : g_lane
            b64bd_lane u_lane (
                .ch  (block[gi*CHAR_W +: CHAR_W]),
                .res (lane_res[gi])
            );
        end
    endgenerate

    b64bd_merge u_merge (
        .lanes (s1_lane_reg),
        .res   (merged)
    );

    assign s2_load  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_load  = in_valid && !in_stall;
    assign in_stall = s1_valid_reg && !s2_load;

    assign s1_valid_next  = s1_load || (s1_valid_reg && !s2_load);
    assign out_valid_next = s2_load || (out_valid_reg && out_stall);

    assign acc       = merged.ok && !stopped_reg;
    assign count_inc = (count_reg > (COUNT_MAX - COUNT_STEP)) ? COUNT_MAX
                                                              : (count_reg + COUNT_STEP);
    always_comb
    begin
        count_next   = acc ? count_inc : count_reg;
        stopped_next = stopped_reg || !merged.ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            stopped_reg   <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s2_load)
            begin
                stopped_reg <= s1_last_reg ? 1'b0 : stopped_next;
                count_reg   <= s1_last_reg ? '0 : count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_lane_reg <= lane_res;
            s1_last_reg <= last_block;
        end
        if (s2_load)
        begin
            out_data_reg <= acc ? merged.data : '0;
            accepted_reg <= acc;
            written_reg  <= count_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign bytes_low     = out_data_reg[63:0];
    assign bytes_high    = out_data_reg[DATA_W-1:64];
    assign accepted      = accepted_reg;
    assign written_count = written_reg;

endmodule

### rtl/b64bd_checker.sv
// ----------------------------------------------------------------------------
// b64bd_checker
// Port-level checks on the decoder outputs, bound to the top level.
// ----------------------------------------------------------------------------
module b64bd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] bytes_low,
    input logic [31:0] bytes_high,
    input logic        accepted,
    input logic [31:0] written_count
);

    // a held result word keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bytes_low)
            && $stable(bytes_high) && $stable(accepted) && $stable(written_count))
        else $error("result word changed while stalled");

    // rejected blocks carry no bytes
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> bytes_low == 64'd0 && bytes_high == 32'd0)
        else $error("rejected block carries data");

    // an accepted block is already in the count
    a_count_incl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> written_count >= 32'd12)
        else $error("count misses accepted block");

endmodule

bind base64_block_decoder_core b64bd_checker u_b64bd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .bytes_low     (bytes_low),
    .bytes_high    (bytes_high),
    .accepted      (accepted),
    .written_count (written_count)
);
